FILE: design/wildcard_pattern_matcher_assert.svh
// Assertion macros shared by the matcher's checker.
`ifndef WILDCARD_PATTERN_MATCHER_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication, switched off while dis is high.
`define WPM_ASSERT_IMP(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("wildcard_pattern_matcher: check failed");

// Next-cycle implication, switched off while dis is high.
`define WPM_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("wildcard_pattern_matcher: check failed");

`endif

FILE: design/wpm_pkg.sv
// Package: widths, codes and symbol constants of the wildcard pattern matcher.
`default_nettype none
package wpm_pkg;
  localparam int MAX_PATTERN = 128;
  localparam int POS_W       = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = 7;
  localparam int SYM_W       = 8;
  localparam int LEVELS      = $clog2(POS_W);

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int CFG_LEN_W   = 8;

  localparam logic [SYM_W-1:0] STAR_BYTE = 8'd42;
  localparam logic [SYM_W-1:0] ANY_BYTE  = 8'd63;

  // Word index of the configuration registers.
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  // Operation codes carried in func.
  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;
endpackage
`default_nettype wire

FILE: design/wpm_item_if.sv
// Input channel: pattern writes and text bytes.
`default_nettype none
interface wpm_item_if;
  import wpm_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] pattern_index;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output func, output pattern_index, output symbol,
                  output last, input ready);
  modport sink (input valid, input func, input pattern_index, input symbol,
                input last, output ready);
endinterface
`default_nettype wire

FILE: design/wpm_result_if.sv
// Output channel: one match result per text byte.
`default_nettype none
interface wpm_result_if;
  logic valid;
  logic ready;
  logic matched;
  logic end_of_text;

  modport source (output valid, output matched, output end_of_text, input ready);
  modport sink (input valid, input matched, input end_of_text, output ready);
endinterface
`default_nettype wire

FILE: design/wpm_closure.sv
// Star closure of a position vector as a parallel-prefix propagate network.
`default_nettype none
module wpm_closure (
  input  logic [wpm_pkg::POS_W-1:0]       seed,
  input  logic [wpm_pkg::MAX_PATTERN-1:0] prop,
  output logic [wpm_pkg::POS_W-1:0]       closed
);
  import wpm_pkg::*;

  // Position i+1 becomes active when position i is active and holds a star:
  // a carry chain with seed as generate and the star flags as propagate.
  logic [POS_W-1:0] g  [LEVELS+1];
  logic [POS_W-1:0] pr [LEVELS+1];

  always_comb begin
    g[0]  = seed;
    pr[0] = {prop, 1'b0};
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < POS_W; i++) begin
        if (i >= (1 << l)) begin
          g[l+1][i]  = g[l][i] | (pr[l][i] & g[l][i-(1<<l)]);
          pr[l+1][i] = pr[l][i] & pr[l][i-(1<<l)];
        end else begin
          g[l+1][i]  = g[l][i];
          pr[l+1][i] = pr[l][i];
        end
      end
    end
    closed = g[LEVELS];
  end
endmodule
`default_nettype wire

FILE: design/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher.
//
//   channel  dir  payload                                    handshake
//   item     in   func, pattern_index, symbol, last          valid/ready
//   result   out  matched, end_of_text                       valid/ready
//   apb      in   pattern_length at byte address 0           psel/penable
//
// An accepted transaction is held in an input register; from there the
// whole active-position update and star closure run in one pass and load the
// result register, so one item per cycle is sustained while the result side
// is not stalled. The star closure is a prefix network over the position vector.
// rst clears control state; the pattern store has no reset. A stalled result
// holds the input register only for text bytes; pattern writes never wait.
`default_nettype none
module wildcard_pattern_matcher (
  input  logic                             clk,
  input  logic                             rst,
  wpm_item_if.sink                         item,
  wpm_result_if.source                     result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wpm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [wpm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [wpm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import wpm_pkg::*;

  // Configuration.
  logic [CFG_LEN_W-1:0]   pattern_length;
  logic [LEN_W-1:0]       eff_len;
  logic [MAX_PATTERN-1:0] use_mask;
  logic                   cfg_wr;
  logic [LEN_W-1:0]       eff_len_next;
  logic [MAX_PATTERN-1:0] use_mask_next;

  // Input register.
  logic             s1_valid;
  logic             s1_func;
  logic [IDX_W-1:0] s1_index;
  logic [SYM_W-1:0] s1_symbol;
  logic             s1_last;
  logic             s1_go;
  logic             out_free;

  // Match state.
  logic [SYM_W-1:0]       store [MAX_PATTERN];
  logic [POS_W-1:0]       active;
  logic                   string_start;
  logic [MAX_PATTERN-1:0] star_v;
  logic [MAX_PATTERN-1:0] hit_v;
  logic [MAX_PATTERN-1:0] prop;
  logic [POS_W-1:0]       start_vec;
  logic [POS_W-1:0]       act;
  logic [MAX_PATTERN-1:0] gen;
  logic [MAX_PATTERN-1:0] adv;
  logic [POS_W-1:0]       seed;
  logic [POS_W-1:0]       active_next;

  // Result register.
  logic out_valid;
  logic out_matched;
  logic out_eot;

  // APB port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_PATTERN_LENGTH);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_PATTERN_LENGTH)
                ? {{(APB_DATA_W-CFG_LEN_W){1'b0}}, pattern_length} : '0;

  always_comb begin
    if (int'(pwdata[CFG_LEN_W-1:0]) > MAX_PATTERN) begin
      eff_len_next = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len_next = LEN_W'(pwdata[CFG_LEN_W-1:0]);
    end
    for (int p = 0; p < MAX_PATTERN; p++) begin
      use_mask_next[p] = (p < int'(eff_len_next));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      eff_len        <= '0;
      use_mask       <= '0;
    end else if (cfg_wr) begin
      pattern_length <= pwdata[CFG_LEN_W-1:0];
      eff_len        <= eff_len_next;
      use_mask       <= use_mask_next;
    end
  end

  // Handshake: a pattern write always leaves the input register, a text byte
  // only when the result register is free or being emptied.
  assign out_free   = !out_valid || result.ready;
  assign s1_go      = s1_valid && ((s1_func == FUNC_PATTERN) || out_free);
  assign item.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_func   <= item.func;
      s1_index  <= item.pattern_index;
      s1_symbol <= item.symbol;
      s1_last   <= item.last;
    end
  end

  // Per-position compare cells.
  always_comb begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      star_v[p] = (store[p] == STAR_BYTE);
      hit_v[p]  = (store[p] == ANY_BYTE) || (store[p] == s1_symbol);
    end
  end

  assign prop = star_v & use_mask;

  wpm_closure u_start_closure (
    .seed   (POS_W'(1)),
    .prop   (prop),
    .closed (start_vec)
  );

  assign act  = string_start ? start_vec : active;
  assign gen  = act[MAX_PATTERN-1:0] & use_mask & star_v;
  assign adv  = act[MAX_PATTERN-1:0] & use_mask & ~star_v & hit_v;
  assign seed = {1'b0, gen} | {adv, 1'b0};

  wpm_closure u_step_closure (
    .seed   (seed),
    .prop   (prop),
    .closed (active_next)
  );

  always_ff @(posedge clk) begin
    if (s1_go && (s1_func == FUNC_PATTERN) && (int'(s1_index) < MAX_PATTERN)) begin
      store[s1_index] <= s1_symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      string_start <= 1'b1;
    end else if (s1_go && (s1_func == FUNC_TEXT)) begin
      active       <= active_next;
      string_start <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && (s1_func == FUNC_TEXT)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_func == FUNC_TEXT)) begin
      out_matched <= active_next[eff_len];
      out_eot     <= s1_last;
    end
  end

  assign result.valid       = out_valid;
  assign result.matched     = out_matched;
  assign result.end_of_text = out_eot;
endmodule
`default_nettype wire

FILE: design/wpm_checker.sv
// Port-level checks on the wildcard pattern matcher, bound to the top level.
`default_nettype none
`include "wildcard_pattern_matcher_assert.svh"
module wpm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_ready,
  input logic                           item_func,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic                           result_matched,
  input logic                           result_end_of_text,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [wpm_pkg::APB_ADDR_W-1:0] paddr,
  input logic [wpm_pkg::APB_DATA_W-1:0] pwdata,
  input logic [wpm_pkg::APB_DATA_W-1:0] prdata
);
  import wpm_pkg::*;

  logic text_taken;
  logic len_write;

  assign text_taken = item_valid && item_ready && (item_func == FUNC_TEXT);
  assign len_write  = psel && penable && pwrite
                    && (paddr[APB_ADDR_W-1:2] == REG_PATTERN_LENGTH);

  // A waiting result keeps its value until it is taken.
  `WPM_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_matched) && $stable(result_end_of_text))

  // Reset empties the result register.
  `WPM_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !result_valid)

  // A text byte taken while nothing waits at the output is answered once it has passed the input and result registers.
  `WPM_ASSERT_NEXT(a_text_answered, clk, rst, text_taken && !result_valid, ##1 result_valid)

  // The length register reads back what was written.
  `WPM_ASSERT_NEXT(a_len_readback, clk, rst, len_write && !$isunknown(pwdata), (paddr[APB_ADDR_W-1:2] != REG_PATTERN_LENGTH) || (prdata[CFG_LEN_W-1:0] == $past(pwdata[CFG_LEN_W-1:0])))
endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
  .clk                (clk),
  .rst                (rst),
  .item_valid         (item.valid),
  .item_ready         (item.ready),
  .item_func          (item.func),
  .result_valid       (result.valid),
  .result_ready       (result.ready),
  .result_matched     (result.matched),
  .result_end_of_text (result.end_of_text),
  .psel               (psel),
  .penable            (penable),
  .pwrite             (pwrite),
  .paddr              (paddr),
  .pwdata             (pwdata),
  .prdata             (prdata)
);
`default_nettype wire
